// ===== hdl/seeded_random_scale_gen_defines.svh =====
// Assertion macros shared by the seeded random scale generator RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef SEEDED_RANDOM_SCALE_GEN_DEFINES_SVH
`define SEEDED_RANDOM_SCALE_GEN_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SRSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srsg: assertion failed");
// next-cycle implication
`define SRSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srsg: assertion failed");
`else
`define SRSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/srsg_pkg.sv =====
// Shared types and constants of the seeded random scale generator.
// No dependencies.
package srsg_pkg;

	typedef struct packed {
		logic [31:0]        unique_id;
		logic signed [31:0] initial_scale_x;
		logic signed [31:0] initial_scale_y;
		logic signed [31:0] initial_scale_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} out_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [31:0]      time_seed;
		logic [2:0][31:0] min_scale;
		logic [2:0][31:0] max_scale;
	} cfg_t;

	// mode bits
	localparam int MODE_CONSISTENT = 0;
	localparam int MODE_UNIFORM    = 1;
	localparam int MODE_OVERRIDE   = 2;

	// register indexes
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_TIME_SEED = 3'd1;
	localparam logic [2:0] REG_MIN_X     = 3'd2;
	localparam logic [2:0] REG_MIN_Y     = 3'd3;
	localparam logic [2:0] REG_MIN_Z     = 3'd4;
	localparam logic [2:0] REG_MAX_X     = 3'd5;
	localparam logic [2:0] REG_MAX_Y     = 3'd6;
	localparam logic [2:0] REG_MAX_Z     = 3'd7;

	localparam logic [31:0] SCALE_ONE  = 32'h0001_0000;
	localparam logic [30:0] LEHMER_MOD = 31'h7FFF_FFFF;
	localparam logic [15:0] LEHMER_MUL = 16'd48271;

endpackage

// ===== hdl/seeded_random_scale_gen.sv =====
// Seeded random scale generator: top level with configuration registers.
// Depends on srsg_pkg, srsg_seed, srsg_lehmer and srsg_scale.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one item per instance: the
//   id and its current Q16.16 scale. Output channel (out_valid/out_stall/
//   out_data) returns exactly one item per input, in order.
//   Configuration is written through cfg_we/cfg_index/cfg_data while the
//   block is idle; index follows the register list (mode, time seed, min x/y/z,
//   max x/y/z).
//   An item passes through 3 seed stages, 6 generator stages (three
//   multiply-by-48271 and fold pairs in series) and 4 scale stages.
//   Throughput is one item per cycle while out_stall is low.
//   Each stage holds its item while the stage after it is full and stalled;
//   empty stages keep filling, so the input is stalled only once every stage
//   up to the first one holds an item. Nothing is dropped or repeated.
//   Reset clears all stage valid bits and sets the registers to their reset
//   values (mode 0, time seed 0, all min/max at 1.0).
module seeded_random_scale_gen
	import srsg_pkg::*;
#(
	parameter int FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data
);

	logic [2:0]       mode_q;
	logic [31:0]      time_seed_q;
	logic [2:0][31:0] min_q;
	logic [2:0][31:0] max_q;
	cfg_t             cfg;

	logic        seed_in_ready, seed_vld, lcg_in_ready, lcg_vld, scl_in_ready;
	logic [30:0] x0, x1, x2, x3;
	in_t         seed_data, lcg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			time_seed_q <= '0;
			min_q       <= {3{SCALE_ONE}};
			max_q       <= {3{SCALE_ONE}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      mode_q      <= cfg_data[2:0];
				REG_TIME_SEED: time_seed_q <= cfg_data;
				REG_MIN_X:     min_q[0]    <= cfg_data;
				REG_MIN_Y:     min_q[1]    <= cfg_data;
				REG_MIN_Z:     min_q[2]    <= cfg_data;
				REG_MAX_X:     max_q[0]    <= cfg_data;
				REG_MAX_Y:     max_q[1]    <= cfg_data;
				REG_MAX_Z:     max_q[2]    <= cfg_data;
			endcase
		end
	end

	always_comb begin
		cfg.mode      = mode_q;
		cfg.time_seed = time_seed_q;
		cfg.min_scale = min_q;
		cfg.max_scale = max_q;
	end

	srsg_seed u_seed (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (seed_in_ready),
		.in_data   (in_data),
		.out_valid (seed_vld),
		.out_ready (lcg_in_ready),
		.x0        (x0),
		.out_data  (seed_data)
	);

	srsg_lehmer u_lehmer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seed_vld),
		.in_ready  (lcg_in_ready),
		.x0        (x0),
		.in_data   (seed_data),
		.out_valid (lcg_vld),
		.out_ready (scl_in_ready),
		.x1        (x1),
		.x2        (x2),
		.x3        (x3),
		.out_data  (lcg_data)
	);

	srsg_scale #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (lcg_vld),
		.in_ready  (scl_in_ready),
		.x1        (x1),
		.x2        (x2),
		.x3        (x3),
		.in_data   (lcg_data),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.out_data  (out_data)
	);

	assign in_stall = !seed_in_ready;

endmodule

// ===== hdl/srsg_seed.sv =====
// Seed pipeline: id mod 11, seed select and shift, reduction mod 2^31-1.
// Depends on srsg_pkg.
module srsg_seed
	import srsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] x0,
	output in_t         out_data
);

	localparam logic [12:0] RECIP_11 = 13'd5958;  // ceil(2^16 / 11)
	localparam logic [10:0] ELEVEN   = 11'd11;

	logic        vld_s1, vld_s2, vld_s3;
	logic        en_s1, en_s2, en_s3;
	logic [11:0] csum_s1;
	logic [3:0]  rem_s2;
	logic [30:0] x0_s3;
	in_t         d_s1, d_s2, d_s3;

	logic [11:0] csum;
	logic [10:0] fold_v;
	logic [23:0] qp;
	logic [10:0] r11;
	logic [31:0] seed;
	logic [31:0] msum;
	logic [30:0] x0_next;

	always_comb begin
		en_s3 = !vld_s3 || out_ready;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
	end
	assign in_ready = en_s1;

	// 2^10 == 1 mod 11, so 10-bit chunks can be summed
	always_comb begin
		csum = 12'(in_data.unique_id[9:0]) + 12'(in_data.unique_id[19:10])
			+ 12'(in_data.unique_id[29:20]) + 12'(in_data.unique_id[31:30]);
	end

	always_comb begin
		fold_v = {1'b0, csum_s1[9:0]} + {9'b0, csum_s1[11:10]};
		qp     = 24'(fold_v) * 24'(RECIP_11);
		r11    = fold_v - 11'(qp[22:16]) * ELEVEN;
	end

	always_comb begin
		if (cfg.mode[MODE_CONSISTENT]) begin
			seed = d_s2.unique_id;
		end else begin
			seed = cfg.time_seed << rem_s2;
		end
		// 2^31 == 1 mod (2^31-1)
		msum = {31'b0, seed[31]} + {1'b0, seed[30:0]};
		if (msum >= {1'b0, LEHMER_MOD}) begin
			msum = msum - {1'b0, LEHMER_MOD};
		end
		x0_next = msum[30:0];
		if (x0_next == '0) begin
			x0_next = 31'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			csum_s1 <= csum;
			d_s1    <= in_data;
		end
		if (en_s2 && vld_s1) begin
			rem_s2 <= r11[3:0];
			d_s2   <= d_s1;
		end
		if (en_s3 && vld_s2) begin
			x0_s3 <= x0_next;
			d_s3  <= d_s2;
		end
	end

	assign out_valid = vld_s3;
	assign x0        = x0_s3;
	assign out_data  = d_s3;

endmodule

// ===== hdl/srsg_lehmer.sv =====
// Lehmer generator pipeline: three successive draws, multiply and fold stages.
// Depends on srsg_pkg and the assertion macro header.
`include "seeded_random_scale_gen_defines.svh"
module srsg_lehmer
	import srsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [30:0] x0,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] x1,
	output logic [30:0] x2,
	output logic [30:0] x3,
	output in_t         out_data
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic        en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic [46:0] p1_s1, p2_s3, p3_s5;
	logic [30:0] x1_s2, x1_s3, x1_s4, x1_s5, x1_s6;
	logic [30:0] x2_s4, x2_s5, x2_s6;
	logic [30:0] x3_s6;
	in_t         d_s1, d_s2, d_s3, d_s4, d_s5, d_s6;

	// p = hi*2^31 + lo == hi + lo mod 2^31-1; one subtract suffices
	function automatic logic [30:0] mod_fold(input logic [46:0] p);
		logic [31:0] s;
		s = {16'b0, p[46:31]} + {1'b0, p[30:0]};
		if (s >= {1'b0, LEHMER_MOD}) begin
			s = s - {1'b0, LEHMER_MOD};
		end
		return s[30:0];
	endfunction

	always_comb begin
		en_s6 = !vld_s6 || out_ready;
		en_s5 = !vld_s5 || en_s6;
		en_s4 = !vld_s4 || en_s5;
		en_s3 = !vld_s3 || en_s4;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
	end
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			p1_s1 <= 47'(x0) * 47'(LEHMER_MUL);
			d_s1  <= in_data;
		end
		if (en_s2 && vld_s1) begin
			x1_s2 <= mod_fold(p1_s1);
			d_s2  <= d_s1;
		end
		if (en_s3 && vld_s2) begin
			p2_s3 <= 47'(x1_s2) * 47'(LEHMER_MUL);
			x1_s3 <= x1_s2;
			d_s3  <= d_s2;
		end
		if (en_s4 && vld_s3) begin
			x2_s4 <= mod_fold(p2_s3);
			x1_s4 <= x1_s3;
			d_s4  <= d_s3;
		end
		if (en_s5 && vld_s4) begin
			p3_s5 <= 47'(x2_s4) * 47'(LEHMER_MUL);
			x2_s5 <= x2_s4;
			x1_s5 <= x1_s4;
			d_s5  <= d_s4;
		end
		if (en_s6 && vld_s5) begin
			x3_s6 <= mod_fold(p3_s5);
			x2_s6 <= x2_s5;
			x1_s6 <= x1_s5;
			d_s6  <= d_s5;
		end
	end

	assign out_valid = vld_s6;
	assign x1        = x1_s6;
	assign x2        = x2_s6;
	assign x3        = x3_s6;
	assign out_data  = d_s6;

	// the generator state never reaches zero or the modulus
	`SRSG_ASSERT_IMP(a_x0_range, clk, arst_n, in_valid, (x0 != '0) && (x0 < LEHMER_MOD))
	`SRSG_ASSERT_IMP(a_x1_range, clk, arst_n, vld_s2, (x1_s2 != '0) && (x1_s2 < LEHMER_MOD))
	`SRSG_ASSERT_IMP(a_x2_range, clk, arst_n, vld_s4, (x2_s4 != '0) && (x2_s4 < LEHMER_MOD))
	`SRSG_ASSERT_IMP(a_x3_range, clk, arst_n, vld_s6, (x3_s6 != '0) && (x3_s6 < LEHMER_MOD))

endmodule

// ===== hdl/srsg_scale.sv =====
// Scale pipeline: draw to fraction, min/max interpolation, multiply (skipped in override mode) and saturate.
// Depends on srsg_pkg.
module srsg_scale
	import srsg_pkg::*;
#(
	parameter int FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [30:0] x1,
	input  logic [30:0] x2,
	input  logic [30:0] x3,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	localparam int SHIFT = 31 - FRACTION_BITS;
	localparam int PW    = 33 + FRACTION_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [PW-1:0] prod_s1 [3];
	logic [2:0][31:0]     init_s1, init_s2;
	logic [31:0]          lerp_s2 [3];
	logic signed [63:0]   m_s3 [3];
	logic [2:0][31:0]     res_s4;

	logic [30:0]            xsel [3];
	logic [30:0]            dm1 [3];
	logic [FRACTION_BITS-1:0] frac [3];
	logic signed [32:0]     diff [3];
	logic signed [PW:0]     pfull [3];
	logic [2:0][31:0]       init_in;
	logic signed [32:0]     lsum [3];
	logic signed [63:0]     m_next [3];
	logic signed [47:0]     t [3];
	logic [31:0]            sat [3];

	always_comb begin
		en_s4 = !vld_s4 || out_ready;
		en_s3 = !vld_s3 || en_s4;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
	end
	assign in_ready = en_s1;

	assign init_in = {in_data.initial_scale_z, in_data.initial_scale_y,
		in_data.initial_scale_x};

	// uniform mode reuses the first draw on every axis
	always_comb begin
		xsel[0] = x1;
		xsel[1] = cfg.mode[MODE_UNIFORM] ? x1 : x2;
		xsel[2] = cfg.mode[MODE_UNIFORM] ? x1 : x3;
		for (int a = 0; a < 3; a++) begin
			dm1[a]   = xsel[a] - 31'd1;
			frac[a]  = dm1[a][30:SHIFT];
			diff[a]  = $signed({cfg.max_scale[a][31], cfg.max_scale[a]})
				- $signed({cfg.min_scale[a][31], cfg.min_scale[a]});
			pfull[a] = (PW+1)'(diff[a]) * (PW+1)'($signed({1'b0, frac[a]}));
		end
	end

	// floor shift of the product; the sum always lies between min and max
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lsum[a] = $signed({cfg.min_scale[a][31], cfg.min_scale[a]})
				+ $signed(prod_s1[a][PW-1:FRACTION_BITS]);
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (cfg.mode[MODE_OVERRIDE]) begin
				m_next[a] = {{16{lerp_s2[a][31]}}, lerp_s2[a], 16'b0};
			end else begin
				m_next[a] = 64'($signed(init_s2[a])) * 64'($signed(lerp_s2[a]));
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			t[a] = m_s3[a][63:16];
			if (t[a][47:31] == '0 || t[a][47:31] == '1) begin
				sat[a] = t[a][31:0];
			end else if (t[a][47]) begin
				sat[a] = 32'h8000_0000;
			end else begin
				sat[a] = 32'h7FFF_FFFF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			for (int a = 0; a < 3; a++) begin
				prod_s1[a] <= pfull[a][PW-1:0];
			end
			init_s1 <= init_in;
		end
		if (en_s2 && vld_s1) begin
			for (int a = 0; a < 3; a++) begin
				lerp_s2[a] <= lsum[a][31:0];
			end
			init_s2 <= init_s1;
		end
		if (en_s3 && vld_s2) begin
			for (int a = 0; a < 3; a++) begin
				m_s3[a] <= m_next[a];
			end
		end
		if (en_s4 && vld_s3) begin
			for (int a = 0; a < 3; a++) begin
				res_s4[a] <= sat[a];
			end
		end
	end

	assign out_valid        = vld_s4;
	assign out_data.scale_x = res_s4[0];
	assign out_data.scale_y = res_s4[1];
	assign out_data.scale_z = res_s4[2];

endmodule

// ===== dv/srsg_scale_checker.sv =====
// Checker for the seeded random scale generator: follows register writes,
// predicts the new scale of every accepted item and compares results in order.
// Depends on srsg_pkg.
module srsg_scale_checker
	import srsg_pkg::*;
#(
	parameter int FRACTION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_data,
	output int          mismatches,
	output int          pending,
	output int          scales_seen
);

	localparam int     Q_FRAC         = 16;
	localparam int     SEED_SHIFT_MOD = 11;
	localparam longint SAT_HI         = 32'h7FFF_FFFF;
	localparam longint SAT_LO         = -longint'(32'h8000_0000);

	cfg_t             regs;
	out_t             expected_scales [$];
	logic [2:0][31:0] got_fields;
	logic [2:0][31:0] want_fields;
	string            field_names [3] = '{"scale_z", "scale_y", "scale_x"};
	int               fail_cnt = 0;
	int               seen_cnt = 0;

	function automatic out_t predict_scale(input in_t item, input cfg_t c);
		logic [31:0]     seed;
		longint unsigned lcg;
		longint unsigned modulus;
		longint unsigned mult;
		longint unsigned frac [3];
		longint          init [3];
		longint          lo;
		longint          hi;
		longint          r;
		logic [31:0]     res [3];
		out_t            o;
		modulus = 64'(LEHMER_MOD);
		mult    = 64'(LEHMER_MUL);
		init[0] = longint'(item.initial_scale_x);
		init[1] = longint'(item.initial_scale_y);
		init[2] = longint'(item.initial_scale_z);
		if (c.mode[MODE_CONSISTENT])
			seed = item.unique_id;
		else
			seed = c.time_seed << (item.unique_id % SEED_SHIFT_MOD);
		lcg = 64'(seed) % modulus;
		if (lcg == 0)
			lcg = 1;
		// uniform mode reuses the first draw on y and z
		for (int a = 0; a < 3; a++) begin
			if (a == 0 || !c.mode[MODE_UNIFORM]) begin
				lcg     = (lcg * mult) % modulus;
				frac[a] = (lcg - 1) >> (31 - FRACTION_BITS);
			end else begin
				frac[a] = frac[0];
			end
		end
		for (int a = 0; a < 3; a++) begin
			lo = longint'($signed(c.min_scale[a]));
			hi = longint'($signed(c.max_scale[a]));
			r  = lo + (((hi - lo) * longint'(frac[a])) >>> FRACTION_BITS);
			if (!c.mode[MODE_OVERRIDE]) begin
				r = (init[a] * r) >>> Q_FRAC;
				if (r > SAT_HI)
					r = SAT_HI;
				else if (r < SAT_LO)
					r = SAT_LO;
			end
			res[a] = r[31:0];
		end
		o.scale_x = res[0];
		o.scale_y = res[1];
		o.scale_z = res[2];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.mode      = '0;
			regs.time_seed = '0;
			regs.min_scale = {3{SCALE_ONE}};
			regs.max_scale = {3{SCALE_ONE}};
			expected_scales.delete();
		end else begin
			if (out_valid && !out_stall) begin
				seen_cnt++;
				if (expected_scales.size() == 0) begin
					$error("result %h arrived with no item in flight", out_data);
					fail_cnt++;
				end else begin
					want_fields = expected_scales.pop_front();
					got_fields  = out_data;
					for (int f = 0; f < 3; f++) begin
						if (got_fields[f] !== want_fields[f]) begin
							$error("%s mismatch: expected %h, actual %h",
								field_names[f], want_fields[f], got_fields[f]);
							fail_cnt++;
						end
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index) inside
					REG_MODE:              regs.mode = cfg_data[2:0];
					REG_TIME_SEED:         regs.time_seed = cfg_data;
					[REG_MIN_X:REG_MIN_Z]:
						regs.min_scale[cfg_index - REG_MIN_X] = cfg_data;
					default:
						regs.max_scale[cfg_index - REG_MAX_X] = cfg_data;
				endcase
			end
			if (in_valid && !in_stall)
				expected_scales.push_back(predict_scale(in_data, regs));
		end
		mismatches  <= fail_cnt;
		pending     <= expected_scales.size();
		scales_seen <= seen_cnt;
	end

endmodule

// ===== dv/tb_top.sv =====
// Top of the seeded random scale generator testbench: clock, reset, register
// settings, item stimulus with random idling and stalls, watchdog and verdict.
// Depends on srsg_pkg, seeded_random_scale_gen and srsg_scale_checker.
module tb_top
	import srsg_pkg::*;
();

	localparam int FRACTION_BITS  = 24;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 9;
	localparam int PHASE_ITEMS    = 150;
	localparam int CALM_PHASE     = 3;
	localparam int IDLE_PERCENT   = 37;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        calm = 1'b0;
	int          mismatches;
	int          pending;
	int          scales_seen;
	int          items_sent = 0;
	int          settings_used = 0;
	int          idle_cycles = 0;

	seeded_random_scale_gen #(
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	srsg_scale_checker #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.mismatches (mismatches),
		.pending    (pending),
		.scales_seen(scales_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// any handshake or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("no progress for %0d cycles", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [31:0] random_scale();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0;
			3, 4:    return $urandom_range(32'h4000, 32'h4_0000);
			5:       return -$urandom_range(32'h4000, 32'h4_0000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input in_t item);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] vals [8]);
		drain_results();
		for (int r = REG_MODE; r <= REG_MAX_Z; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= r[2:0];
			cfg_data  <= vals[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		logic [31:0] vals [8];
		logic [31:0] corners [4];
		in_t         item;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, SCALE_ONE};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ranges are 1.0, so multiply mode hands back the input scale
		item.unique_id       = 32'd5;
		item.initial_scale_x = 32'h7FFF_FFFF;
		item.initial_scale_y = 32'h8000_0000;
		item.initial_scale_z = 32'hFFFF_FFFF;
		send_item(item);

		// every mode with full-span, descending and sign-crossing ranges;
		// ids give a zero seed, a seed equal to the modulus and the largest shift
		for (int m = 0; m < 8; m++) begin
			vals[REG_MODE]      = ($urandom & ~32'h7) | m;
			vals[REG_TIME_SEED] = m[2] ? 32'hFFFF_FFFF : 32'h0;
			vals[REG_MIN_X]     = 32'h8000_0000;
			vals[REG_MAX_X]     = 32'h7FFF_FFFF;
			vals[REG_MIN_Y]     = 32'h7FFF_FFFF;
			vals[REG_MAX_Y]     = 32'h8000_0000;
			vals[REG_MIN_Z]     = 32'h0002_0000;
			vals[REG_MAX_Z]     = 32'hFFFF_8000;
			apply_settings(vals);
			for (int k = 0; k < 3; k++) begin
				item.unique_id = (k == 0) ? 32'd0 : (k == 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFB;
				item.initial_scale_x = corners[(k + m) % 4];
				item.initial_scale_y = corners[(k + m + 1) % 4];
				item.initial_scale_z = corners[(k + m + 2) % 4];
				send_item(item);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			vals[REG_MODE] = $urandom;
			case ($urandom_range(0, 3))
				0:       vals[REG_TIME_SEED] = 32'h0;
				1:       vals[REG_TIME_SEED] = 32'hFFFF_FFFF;
				default: vals[REG_TIME_SEED] = $urandom;
			endcase
			for (int r = REG_MIN_X; r <= REG_MAX_Z; r++)
				vals[r] = random_scale();
			apply_settings(vals);
			calm <= (p == CALM_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 3))
					0:       item.unique_id = $urandom_range(0, 40);
					1:       item.unique_id = 32'h7FFF_FFFF << $urandom_range(0, 1);
					default: item.unique_id = $urandom;
				endcase
				item.initial_scale_x = random_scale();
				item.initial_scale_y = random_scale();
				item.initial_scale_z = random_scale();
				send_item(item);
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d items over %0d register settings.",
			scales_seen, items_sent, settings_used);
		$display("Settings spanned all mode combinations, zero and shifted seeds, extreme ranges.");
		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/srsg_pkg.sv
hdl/srsg_seed.sv
hdl/srsg_lehmer.sv
hdl/srsg_scale.sv
hdl/seeded_random_scale_gen.sv
dv/srsg_scale_checker.sv
dv/tb_top.sv
